// ----- rtl/core/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants for the string intern table
// Sizes of the symbol table, byte store and pending buffer, result status
// codes, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    // Table and store sizes
    localparam int MAX_SYMBOLS = 256;
    localparam int STORE_BYTES = 4096;
    localparam int MAX_LENGTH  = 255;
    localparam int PEND_DEPTH  = 256;

    // Derived widths
    localparam int COUNT_W  = $clog2(MAX_SYMBOLS + 1);   // 0..MAX_SYMBOLS
    localparam int OFF_W    = $clog2(STORE_BYTES + 1);   // 0..STORE_BYTES
    localparam int STORE_AW = $clog2(STORE_BYTES);
    localparam int PEND_AW  = $clog2(PEND_DEPTH);
    localparam int LEN_W    = $clog2(MAX_LENGTH + 2);    // 0..MAX_LENGTH+1
    localparam int NUM_W    = 8;

    // Operation codes
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN_WAIT,
        ST_LEN_CHK,
        ST_BYTE_WAIT,
        ST_BYTE_CHK,
        ST_MISS,
        ST_COPY_WAIT,
        ST_COPY_WR,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/string_intern_table.sv -----
// ----------------------------------------------------------------------------
// string_intern_table: byte string interning symbol table
// Usage:
//   Input beats (s_*) carry one byte (operation 0) or a close (operation 1).
//   A byte beat gives no result. A close beat starts a search over the
//   stored symbols in order; each yields exactly one result beat (m_*)
//   with the symbol number, a found flag and a status.
//   A close walks these steps: for each symbol visited, a length check (end
//   offset memory read); when lengths agree, a compare of each byte (byte
//   store and pending buffer reads); on a miss, a room check and a copy of
//   each byte; then a load of the output register.
//   s_ready is low for the whole search; one item is worked on at a time.
//   Results sit in an output register: byte beats and the next close are
//   taken while a result waits, and the sequencer holds in its final state
//   only if a second result is ready before the first is taken.
//   Reset empties the symbol table, the store and the pending string; no
//   clearing pass is needed, since only written entries are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module string_intern_table (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    input  wire logic [7:0] s_char_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_symbol_number,
    output logic            m_was_present,
    output logic [1:0]      m_status
);

    localparam int COUNT_W  = sit_pkg::COUNT_W;
    localparam int OFF_W    = sit_pkg::OFF_W;
    localparam int STORE_AW = sit_pkg::STORE_AW;
    localparam int PEND_AW  = sit_pkg::PEND_AW;
    localparam int LEN_W    = sit_pkg::LEN_W;
    localparam int NUM_W    = sit_pkg::NUM_W;

    sit_pkg::state_t state_reg, state_next;

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic [COUNT_W-1:0] sym_idx_reg, sym_idx_next;
    logic [OFF_W-1:0]   base_reg,    base_next;
    logic [OFF_W-1:0]   start_reg,   start_next;
    logic [LEN_W-1:0]   len_reg,     len_next;
    logic [LEN_W-1:0]   k_reg,       k_next;
    logic [NUM_W-1:0]   res_num_reg, res_num_next;
    logic               res_pres_reg, res_pres_next;
    logic [1:0]         res_stat_reg, res_stat_next;

    logic               m_valid_reg, m_valid_next;
    logic [NUM_W-1:0]   m_num_reg,   m_num_next;
    logic               m_pres_reg,  m_pres_next;
    logic [1:0]         m_stat_reg,  m_stat_next;

    // Handshake decode
    logic in_beat, byte_beat, close_beat;
    assign s_ready    = (state_reg == sit_pkg::ST_IDLE);
    assign in_beat    = s_valid && s_ready;
    assign byte_beat  = in_beat && (s_operation == sit_pkg::OP_BYTE);
    assign close_beat = in_beat && (s_operation == sit_pkg::OP_CLOSE);

    // Pending string buffer
    logic [7:0]       pend_rd;
    logic [LEN_W-1:0] pend_len;

    sit_pending u_pending (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (byte_beat),
        .push_byte (s_char_byte),
        .clear     (close_beat),
        .rd_addr   (k_reg[PEND_AW-1:0]),
        .rd_data   (pend_rd),
        .length    (pend_len)
    );

    // End offset memory; entry zero is never read, start of symbol 0 is 0
    logic [OFF_W-1:0]   end_mem [0:sit_pkg::MAX_SYMBOLS];
    logic [OFF_W-1:0]   end_rd_reg;
    logic [COUNT_W-1:0] end_rd_addr;
    logic               end_we;

    assign end_rd_addr = sym_idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (end_we) begin
            end_mem[count_reg + 1'b1] <= base_reg + OFF_W'(len_reg);
        end
        end_rd_reg <= end_mem[end_rd_addr];
    end

    // Packed symbol byte store
    logic [7:0]       store_mem [0:sit_pkg::STORE_BYTES-1];
    logic [7:0]       store_rd_reg;
    logic [OFF_W-1:0] store_rd_sum, store_wr_sum;
    logic             store_we;

    assign store_rd_sum = start_reg + OFF_W'(k_reg);
    assign store_wr_sum = base_reg + OFF_W'(k_reg);

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_wr_sum[STORE_AW-1:0]] <= pend_rd;
        end
        store_rd_reg <= store_mem[store_rd_sum[STORE_AW-1:0]];
    end

    // Shared compare terms
    logic [OFF_W-1:0] sym_len, space_left;
    logic             k_last, idx_last;
    assign sym_len    = end_rd_reg - start_reg;
    assign space_left = OFF_W'(sit_pkg::STORE_BYTES) - base_reg;
    assign k_last     = ((k_reg + 1'b1) == len_reg);
    assign idx_last   = ((sym_idx_reg + 1'b1) == count_reg);

    // State register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sit_pkg::ST_IDLE;
            count_reg   <= '0;
            base_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_idx_reg  <= sym_idx_next;
        start_reg    <= start_next;
        len_reg      <= len_next;
        k_reg        <= k_next;
        res_num_reg  <= res_num_next;
        res_pres_reg <= res_pres_next;
        res_stat_reg <= res_stat_next;
        m_num_reg    <= m_num_next;
        m_pres_reg   <= m_pres_next;
        m_stat_reg   <= m_stat_next;
    end

    // Sequencer: search, append, result
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        sym_idx_next  = sym_idx_reg;
        base_next     = base_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        k_next        = k_reg;
        res_num_next  = res_num_reg;
        res_pres_next = res_pres_reg;
        res_stat_next = res_stat_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_num_next    = m_num_reg;
        m_pres_next   = m_pres_reg;
        m_stat_next   = m_stat_reg;
        end_we        = 1'b0;
        store_we      = 1'b0;

        unique case (state_reg)
            sit_pkg::ST_IDLE: begin
                if (close_beat) begin
                    len_next      = pend_len;
                    res_num_next  = '0;
                    res_pres_next = 1'b0;
                    res_stat_next = sit_pkg::STATUS_OK;
                    sym_idx_next  = '0;
                    start_next    = '0;
                    k_next        = '0;
                    if (pend_len > LEN_W'(sit_pkg::MAX_LENGTH)) begin
                        res_stat_next = sit_pkg::STATUS_TOO_LONG;
                        state_next    = sit_pkg::ST_DONE;
                    end else if (count_reg == '0) begin
                        state_next = sit_pkg::ST_MISS;
                    end else begin
                        state_next = sit_pkg::ST_LEN_WAIT;
                    end
                end
            end

            sit_pkg::ST_LEN_WAIT: begin
                state_next = sit_pkg::ST_LEN_CHK;
            end

            // Length check of the current symbol
            sit_pkg::ST_LEN_CHK: begin
                if (sym_len == OFF_W'(len_reg)) begin
                    if (len_reg == '0) begin
                        res_num_next  = sym_idx_reg[NUM_W-1:0];
                        res_pres_next = 1'b1;
                        state_next    = sit_pkg::ST_DONE;
                    end else begin
                        k_next     = '0;
                        state_next = sit_pkg::ST_BYTE_WAIT;
                    end
                end else begin
                    start_next = end_rd_reg;
                    if (idx_last) begin
                        state_next = sit_pkg::ST_MISS;
                    end else begin
                        sym_idx_next = sym_idx_reg + 1'b1;
                        state_next   = sit_pkg::ST_LEN_WAIT;
                    end
                end
            end

            sit_pkg::ST_BYTE_WAIT: begin
                state_next = sit_pkg::ST_BYTE_CHK;
            end

            // Byte compare of the current symbol
            sit_pkg::ST_BYTE_CHK: begin
                if (store_rd_reg == pend_rd) begin
                    if (k_last) begin
                        res_num_next  = sym_idx_reg[NUM_W-1:0];
                        res_pres_next = 1'b1;
                        state_next    = sit_pkg::ST_DONE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = sit_pkg::ST_BYTE_WAIT;
                    end
                end else begin
                    start_next = end_rd_reg;
                    if (idx_last) begin
                        state_next = sit_pkg::ST_MISS;
                    end else begin
                        sym_idx_next = sym_idx_reg + 1'b1;
                        state_next   = sit_pkg::ST_LEN_WAIT;
                    end
                end
            end

            // No match: check room, then append or commit an empty string
            sit_pkg::ST_MISS: begin
                k_next = '0;
                if (count_reg >= COUNT_W'(sit_pkg::MAX_SYMBOLS) ||
                    OFF_W'(len_reg) > space_left) begin
                    res_stat_next = sit_pkg::STATUS_FULL;
                    state_next    = sit_pkg::ST_DONE;
                end else if (len_reg == '0) begin
                    end_we       = 1'b1;
                    base_next    = base_reg;
                    res_num_next = count_reg[NUM_W-1:0];
                    count_next   = count_reg + 1'b1;
                    state_next   = sit_pkg::ST_DONE;
                end else begin
                    state_next = sit_pkg::ST_COPY_WAIT;
                end
            end

            sit_pkg::ST_COPY_WAIT: begin
                state_next = sit_pkg::ST_COPY_WR;
            end

            // Copy one pending byte into the store
            sit_pkg::ST_COPY_WR: begin
                store_we = 1'b1;
                if (k_last) begin
                    end_we       = 1'b1;
                    base_next    = base_reg + OFF_W'(len_reg);
                    res_num_next = count_reg[NUM_W-1:0];
                    count_next   = count_reg + 1'b1;
                    state_next   = sit_pkg::ST_DONE;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = sit_pkg::ST_COPY_WAIT;
                end
            end

            // Hand the result to the output register once it is free
            sit_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_num_next   = res_num_reg;
                    m_pres_next  = res_pres_reg;
                    m_stat_next  = res_stat_reg;
                    state_next   = sit_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = sit_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_symbol_number = m_num_reg;
    assign m_was_present   = m_pres_reg;
    assign m_status        = m_stat_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(sit_pkg::MAX_SYMBOLS))
        else $error("symbol count beyond table size");

    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg <= OFF_W'(sit_pkg::STORE_BYTES))
        else $error("store fill beyond store size");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg != sit_pkg::STATUS_OK) |->
        (m_num_reg == '0 && !m_pres_reg))
        else $error("error result carries a symbol");

    a_found_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_pres_reg) |-> (COUNT_W'(m_num_reg) < count_reg))
        else $error("found symbol number not in table");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        end_we |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance symbol count");

endmodule

`default_nettype wire

// ----- rtl/core/sit_pending.sv -----
// ----------------------------------------------------------------------------
// sit_pending: pending string buffer
// Collects the bytes of the string being built, saturates its length one
// past the maximum, and offers one registered read port to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_pending (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         push,
    input  wire logic [7:0]                   push_byte,
    input  wire logic                         clear,
    input  wire logic [sit_pkg::PEND_AW-1:0]  rd_addr,
    output logic      [7:0]                   rd_data,
    output logic      [sit_pkg::LEN_W-1:0]    length
);

    logic [7:0]                mem [0:sit_pkg::PEND_DEPTH-1];
    logic [7:0]                rd_data_reg;
    logic [sit_pkg::LEN_W-1:0] len_reg;
    logic [sit_pkg::LEN_W-1:0] len_next;
    logic                      wr_en;

    // Length counter with saturation; a close empties the string
    always_comb begin
        len_next = len_reg;
        wr_en    = 1'b0;
        if (clear) begin
            len_next = '0;
        end else if (push) begin
            if (len_reg < sit_pkg::LEN_W'(sit_pkg::MAX_LENGTH)) begin
                wr_en    = 1'b1;
                len_next = len_reg + 1'b1;
            end else begin
                len_next = sit_pkg::LEN_W'(sit_pkg::MAX_LENGTH + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    // Byte buffer: one write, one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[len_reg[sit_pkg::PEND_AW-1:0]] <= push_byte;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign length  = len_reg;

endmodule

`default_nettype wire
